// File: rtl/core/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants for the largest prime factor block
// Holds the controller states and the command/status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpf_pkg;

   localparam int unsigned DATA_WIDTH    = 32;
   localparam int unsigned FIRST_DIVISOR = 2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_DIV   = 5'b00100,
      S_STEP  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;       // take a new number, reset divisor and best factor
      logic div_start;  // begin a division of the remaining value
      logic div_step;   // one restoring division step
      logic update;     // apply the division outcome to value and divisor
      logic store;      // write the answer to the output register
   } cmd_type;

   typedef struct packed {
      logic below_two;  // remaining value below two
      logic div_last;   // last division step this cycle
      logic finish;     // divisor exceeds the square root bound
      logic out_free;   // output register empty or being drained
   } status_type;

endpackage

// File: rtl/core/largest_prime_factor.sv
// ----------------------------------------------------------------------------
// largest_prime_factor: largest prime factor by trial division
// Divides out trial divisors from 2 upward until the divisor passes the
// square root of the remaining value; a remainder above one is the answer.
//
//   channel  dir  fields (tdata, lowest bit up)
//   req_     in   number[31:0]
//   rsp_     out  largest_factor[31:0]
//
// Each division runs through the bit-serial restoring divider and is
// followed by a decision step; a prime 32-bit input needs about 65536
// divisions.
// One item is in work at a time; a new word is taken while the previous
// answer still waits in the output register.
// Reset is synchronous and clears only control state; nothing else to clear.
// A stalled result holds the finished item in the done state until taken.
// ----------------------------------------------------------------------------
module largest_prime_factor #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: number
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lpf_pkg::DATA_WIDTH-1:0] req_tdata,   // [31:0] number
   // response: largest_factor
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lpf_pkg::DATA_WIDTH-1:0] rsp_tdata    // [31:0] largest_factor
);
   import lpf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: load, divide, decide, store
   lpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // value, divisor, divider and output register
   lpf_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // after taking a word, hold off the next until this one is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new word accepted while an item is in work");

   // never overwrite an answer that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten");

   // load, divide and store commands never overlap
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.store}))
      else $error("conflicting datapath commands");

   // a store follows only a completed item, never a division step
   a_store_after_step: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> !cmd.store)
      else $error("store issued straight after a division step");

endmodule

// File: rtl/core/lpf_ctrl.sv
// ----------------------------------------------------------------------------
// lpf_ctrl: sequencer for trial division
// Steps through load, repeated division and the per-divisor decision, and
// hands the answer to the output register when it is free.
// ----------------------------------------------------------------------------
module lpf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lpf_pkg::status_type status,
   output lpf_pkg::cmd_type    cmd
);
   import lpf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            // values below two have no factor; answer is zero
            if (status.below_two) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (status.finish) begin
               state_in = S_DONE;
            end else begin
               cmd.update    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.store = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/lpf_dpath.sv
// ----------------------------------------------------------------------------
// lpf_dpath: trial division datapath
// Holds remaining value, divisor and best factor, a one-bit-per-cycle
// restoring divider, and the output register.
// ----------------------------------------------------------------------------
module lpf_dpath #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lpf_pkg::DATA_WIDTH-1:0]    req_tdata,
   input  lpf_pkg::cmd_type                  cmd,
   output lpf_pkg::status_type               status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpf_pkg::DATA_WIDTH-1:0]    rsp_tdata
);
   import lpf_pkg::*;

   localparam int unsigned W     = VALUE_WIDTH;
   localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

   logic [W-1:0]     n_ff, n_in;
   logic [W-1:0]     d_ff, d_in;
   logic [W-1:0]     best_ff, best_in;
   logic             inner_ff, inner_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic             out_valid_ff, out_valid_in;

   logic [W-1:0]     in_value;
   logic [W-1:0]     answer;
   logic [DATA_WIDTH-1:0] answer_out;
   logic [W:0]       shifted;
   logic [W:0]       trial;

   generate
      if (W >= DATA_WIDTH) begin : g_wide
         assign in_value   = W'(req_tdata);
         assign answer_out = answer[DATA_WIDTH-1:0];
      end else begin : g_narrow
         assign in_value   = req_tdata[W-1:0];
         assign answer_out = DATA_WIDTH'(answer);
      end
   endgenerate

   // any remainder above one is prime and beats every divisor found
   assign answer = (n_ff > W'(1)) ? n_ff : best_ff;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, d_ff};

   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      best_in      = best_ff;
      inner_in     = inner_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;

      if (cmd.load) begin
         n_in     = in_value;
         d_in     = W'(FIRST_DIVISOR);
         best_in  = '0;
         inner_in = 1'b0;
      end

      if (cmd.update) begin
         if (rem_ff == '0) begin
            // divides: drop the factor and try the same divisor again
            best_in  = d_ff;
            n_in     = quo_ff;
            inner_in = 1'b1;
         end else begin
            d_in     = d_ff + W'(1);
            inner_in = 1'b0;
         end
      end

      if (cmd.div_start) begin
         quo_in = n_in;
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.store) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      best_ff  <= best_in;
      inner_ff <= inner_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (cmd.store) begin
         out_data_ff <= answer_out;
      end
   end

   assign status.below_two = (n_ff < W'(2));
   assign status.div_last  = (cnt_ff == CNT_W'(W - 1));
   // bound is checked only on the first division for each divisor
   assign status.finish    = !inner_ff && (d_ff > quo_ff);
   assign status.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
